// ----- design/i2r_pkg.sv -----
// Package for the integer to Roman numeral converter: microcode format, program and term tables.
`timescale 1ns / 1ps
`default_nettype none

package i2r_pkg;

	localparam int VALUE_W  = 14;
	localparam int SYM_W    = 7;
	localparam int PC_W     = 4;
	localparam int TERM_W   = 4;
	localparam int TVAL_W   = 10;
	localparam int N_TERMS  = 13;

	localparam logic [VALUE_W-1:0] MAX_VALUE = VALUE_W'(3999);

	localparam logic [SYM_W-1:0] CH_NONE = 7'h00;
	localparam logic [SYM_W-1:0] CH_M    = 7'h4D;
	localparam logic [SYM_W-1:0] CH_D    = 7'h44;
	localparam logic [SYM_W-1:0] CH_C    = 7'h43;
	localparam logic [SYM_W-1:0] CH_L    = 7'h4C;
	localparam logic [SYM_W-1:0] CH_X    = 7'h58;
	localparam logic [SYM_W-1:0] CH_V    = 7'h56;
	localparam logic [SYM_W-1:0] CH_I    = 7'h49;

	// program addresses
	localparam logic [PC_W-1:0] S_WAIT   = 4'd0;
	localparam logic [PC_W-1:0] S_ZCHK   = 4'd1;
	localparam logic [PC_W-1:0] S_OCHK   = 4'd2;
	localparam logic [PC_W-1:0] S_TEST   = 4'd3;
	localparam logic [PC_W-1:0] S_EMIT_A = 4'd4;
	localparam logic [PC_W-1:0] S_EMIT_B = 4'd5;
	localparam logic [PC_W-1:0] S_LOOP   = 4'd6;
	localparam logic [PC_W-1:0] S_DONE   = 4'd7;
	localparam logic [PC_W-1:0] S_EMPTY  = 4'd8;
	localparam logic [PC_W-1:0] S_ERROR  = 4'd9;

	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_NO_VALID,
		C_ZERO,
		C_NZ,
		C_OVER,
		C_NOFIT,
		C_NO_SECOND
	} cond_t;

	typedef enum logic [2:0] {
		E_NONE,
		E_FIRST,
		E_SECOND,
		E_EMPTY,
		E_ERROR
	} emit_t;

	typedef struct packed {
		logic            in_rdy;
		logic            load;
		logic            inc_t;
		logic            sub;
		emit_t           emit;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} uword_t;

	// jump to target when cond holds, else fall through
	function automatic uword_t prog(input logic [PC_W-1:0] pc);
		uword_t w;
		case (pc)
			S_WAIT:   w = '{1'b1, 1'b1, 1'b0, 1'b0, E_NONE,   C_NO_VALID,  S_WAIT};
			S_ZCHK:   w = '{1'b0, 1'b0, 1'b0, 1'b0, E_NONE,   C_ZERO,      S_EMPTY};
			S_OCHK:   w = '{1'b0, 1'b0, 1'b0, 1'b0, E_NONE,   C_OVER,      S_ERROR};
			S_TEST:   w = '{1'b0, 1'b0, 1'b1, 1'b0, E_NONE,   C_NOFIT,     S_TEST};
			S_EMIT_A: w = '{1'b0, 1'b0, 1'b0, 1'b1, E_FIRST,  C_NO_SECOND, S_LOOP};
			S_EMIT_B: w = '{1'b0, 1'b0, 1'b0, 1'b0, E_SECOND, C_NEXT,      S_LOOP};
			S_LOOP:   w = '{1'b0, 1'b0, 1'b0, 1'b0, E_NONE,   C_NZ,        S_TEST};
			S_DONE:   w = '{1'b0, 1'b0, 1'b0, 1'b0, E_NONE,   C_ALWAYS,    S_WAIT};
			S_EMPTY:  w = '{1'b0, 1'b0, 1'b0, 1'b0, E_EMPTY,  C_ALWAYS,    S_WAIT};
			S_ERROR:  w = '{1'b0, 1'b0, 1'b0, 1'b0, E_ERROR,  C_ALWAYS,    S_WAIT};
			default:  w = '{1'b0, 1'b0, 1'b0, 1'b0, E_NONE,   C_ALWAYS,    S_WAIT};
		endcase
		return w;
	endfunction

	function automatic logic [TVAL_W-1:0] term_value(input logic [TERM_W-1:0] t);
		logic [TVAL_W-1:0] v;
		case (t)
			4'd0:    v = TVAL_W'(1000);
			4'd1:    v = TVAL_W'(900);
			4'd2:    v = TVAL_W'(500);
			4'd3:    v = TVAL_W'(400);
			4'd4:    v = TVAL_W'(100);
			4'd5:    v = TVAL_W'(90);
			4'd6:    v = TVAL_W'(50);
			4'd7:    v = TVAL_W'(40);
			4'd8:    v = TVAL_W'(10);
			4'd9:    v = TVAL_W'(9);
			4'd10:   v = TVAL_W'(5);
			4'd11:   v = TVAL_W'(4);
			default: v = TVAL_W'(1);
		endcase
		return v;
	endfunction

	function automatic logic [SYM_W-1:0] term_first(input logic [TERM_W-1:0] t);
		logic [SYM_W-1:0] c;
		case (t)
			4'd0:    c = CH_M;
			4'd1:    c = CH_C;
			4'd2:    c = CH_D;
			4'd3:    c = CH_C;
			4'd4:    c = CH_C;
			4'd5:    c = CH_X;
			4'd6:    c = CH_L;
			4'd7:    c = CH_X;
			4'd8:    c = CH_X;
			4'd9:    c = CH_I;
			4'd10:   c = CH_V;
			default: c = CH_I;
		endcase
		return c;
	endfunction

	function automatic logic [SYM_W-1:0] term_second(input logic [TERM_W-1:0] t);
		logic [SYM_W-1:0] c;
		case (t)
			4'd1:    c = CH_M;
			4'd3:    c = CH_D;
			4'd5:    c = CH_C;
			4'd7:    c = CH_L;
			4'd9:    c = CH_X;
			4'd11:   c = CH_V;
			default: c = CH_NONE;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- design/integer_to_roman.sv -----
// Integer to Roman numeral converter: microcoded sequencer with a subtract datapath.
//
// A request on the input channel (in_valid/in_ready, field value) carries an
// unsigned integer. Each result on the output channel (out_valid/out_ready)
// is one ASCII numeral character in symbol with has_symbol set; last marks
// the final character of the run. Zero gives one empty result with last set;
// a value above 3999 gives one result with out_of_range and last set.
// in_ready is high only while the sequencer sits in its wait step, so one
// request is converted at a time. An accepted request passes the zero check,
// then the range check; the term search then passes over each term that does
// not fit, emits the first letter of the term that fits and subtracts its
// value, emits the second letter of a two-letter term, and loops while a
// remainder is left. The output register is free to take the next character
// while the receiver drains the last one; when out_ready is low with a
// result pending, the step that emits stalls and the sequencer holds.
// Reset returns the sequencer to its wait step with no result pending.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_roman (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [i2r_pkg::VALUE_W-1:0]      value,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [i2r_pkg::SYM_W-1:0]        symbol,
	output logic                             has_symbol,
	output logic                             last,
	output logic                             out_of_range
);

	logic [i2r_pkg::PC_W-1:0]    pc_q;
	logic [i2r_pkg::VALUE_W-1:0] rest_q;
	logic [i2r_pkg::TERM_W-1:0]  t_q;
	logic                        out_valid_q;
	logic [i2r_pkg::SYM_W-1:0]   symbol_q;
	logic                        has_symbol_q;
	logic                        last_q;
	logic                        oor_q;

	i2r_pkg::uword_t             uw;
	logic [i2r_pkg::VALUE_W-1:0] tval;
	logic [i2r_pkg::SYM_W-1:0]   ch_first;
	logic [i2r_pkg::SYM_W-1:0]   ch_second;
	logic                        fits;
	logic                        cond_true;
	logic                        stall;
	logic [i2r_pkg::PC_W-1:0]    pc_d;

	assign uw        = i2r_pkg::prog(pc_q);
	assign tval      = i2r_pkg::VALUE_W'(i2r_pkg::term_value(t_q));
	assign ch_first  = i2r_pkg::term_first(t_q);
	assign ch_second = i2r_pkg::term_second(t_q);
	assign fits      = rest_q >= tval;
	assign stall     = (uw.emit != i2r_pkg::E_NONE) && out_valid_q && !out_ready;

	always_comb begin
		case (uw.cond)
			i2r_pkg::C_NEXT:      cond_true = 1'b0;
			i2r_pkg::C_ALWAYS:    cond_true = 1'b1;
			i2r_pkg::C_NO_VALID:  cond_true = !in_valid;
			i2r_pkg::C_ZERO:      cond_true = rest_q == '0;
			i2r_pkg::C_NZ:        cond_true = rest_q != '0;
			i2r_pkg::C_OVER:      cond_true = rest_q > i2r_pkg::MAX_VALUE;
			i2r_pkg::C_NOFIT:     cond_true = !fits;
			i2r_pkg::C_NO_SECOND: cond_true = ch_second == i2r_pkg::CH_NONE;
			default:              cond_true = 1'b1;
		endcase
	end

	always_comb begin
		if (stall) begin
			pc_d = pc_q;
		end else if (cond_true) begin
			pc_d = uw.target;
		end else begin
			pc_d = pc_q + 1'b1;
		end
	end

	assign in_ready = uw.in_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= i2r_pkg::S_WAIT;
		end else begin
			pc_q <= pc_d;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (uw.load && in_valid) begin
			rest_q <= value;
			t_q    <= '0;
		end else if (!stall) begin
			if (uw.sub) begin
				rest_q <= rest_q - tval;
			end
			if (uw.inc_t && !fits) begin
				t_q <= t_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!stall && uw.emit != i2r_pkg::E_NONE) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			case (uw.emit)
				i2r_pkg::E_FIRST: begin
					symbol_q     <= ch_first;
					has_symbol_q <= 1'b1;
					last_q       <= (ch_second == i2r_pkg::CH_NONE) && (rest_q == tval);
					oor_q        <= 1'b0;
				end
				i2r_pkg::E_SECOND: begin
					symbol_q     <= ch_second;
					has_symbol_q <= 1'b1;
					last_q       <= rest_q == '0;
					oor_q        <= 1'b0;
				end
				i2r_pkg::E_EMPTY: begin
					symbol_q     <= i2r_pkg::CH_NONE;
					has_symbol_q <= 1'b0;
					last_q       <= 1'b1;
					oor_q        <= 1'b0;
				end
				i2r_pkg::E_ERROR: begin
					symbol_q     <= i2r_pkg::CH_NONE;
					has_symbol_q <= 1'b0;
					last_q       <= 1'b1;
					oor_q        <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign symbol       = symbol_q;
	assign has_symbol   = has_symbol_q;
	assign last         = last_q;
	assign out_of_range = oor_q;

	a_accept_to_zchk: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (pc_q == i2r_pkg::S_ZCHK))
		else $error("accepted request did not enter the zero check");

	a_test_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == i2r_pkg::S_TEST) |-> (rest_q != '0 && t_q < i2r_pkg::TERM_W'(i2r_pkg::N_TERMS)))
		else $error("term search with nothing left or past the last term");

	a_oor_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_of_range) |-> (last && !has_symbol))
		else $error("out-of-range result not a lone final result");

	a_emit_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == i2r_pkg::S_EMIT_A) |-> fits)
		else $error("character emitted for a term that does not fit");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> (pc_q == $past(pc_q) && rest_q == $past(rest_q)))
		else $error("sequencer advanced while output stalled");

endmodule

`default_nettype wire
